/* hw/rtl/rgbc_pkg.sv */
// Shared types, constants and helpers for the RGB 3x3 convolution filter.
// Used by rgbc_line_store, rgbc_tap_cell and rgb_conv3x3_filter; no dependencies.
package rgbc_pkg;

	localparam int PIX_W     = 8;
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 8;
	localparam int CFG_DIM_W = 11;
	localparam int CFG_ROW_W = 3 * COEF_W;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = PIX_W + 1 + COEF_W;
	localparam int COL_SUM_W = PROD_W + 2;
	localparam int SUM_W     = COL_SUM_W + 2;
	localparam int LINE_W    = 6 * PIX_W;

	localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = CFG_DIM_W'(640);
	localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = CFG_DIM_W'(480);
	localparam logic [CFG_ROW_W-1:0] COEF_TOP_RST     = '0;
	localparam logic [CFG_ROW_W-1:0] COEF_MID_RST     = 48'h0000_0100_0000;
	localparam logic [CFG_ROW_W-1:0] COEF_BOT_RST     = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_COEF_TOP     = 3'd2,
		CFG_COEF_MID     = 3'd3,
		CFG_COEF_BOT     = 3'd4
	} cfg_reg_t;

	// how far the input position is into the frame, for the start of output
	typedef enum logic [1:0] {
		ROW_FIRST,
		ROW_SECOND,
		ROW_LATER
	} row_phase_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pix_t;

	typedef struct packed {
		pix_t bot;
		pix_t mid;
		pix_t top;
	} win_col_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] bot;
		logic signed [COEF_W-1:0] mid;
		logic signed [COEF_W-1:0] top;
	} coef_col_t;

	typedef struct packed {
		logic signed [COL_SUM_W-1:0] blue;
		logic signed [COL_SUM_W-1:0] green;
		logic signed [COL_SUM_W-1:0] red;
	} col_sum_t;

	typedef struct packed {
		logic shift;
		logic calc;
		logic top_ok;
		logic bot_ok;
	} cell_ctl_t;

	typedef struct packed {
		logic emit;
		logic left_ok;
		logic right_ok;
		logic top_ok;
		logic bot_ok;
		logic last;
	} pos_flags_t;

	function automatic logic signed [PROD_W-1:0] mul_tap(
		input logic [PIX_W-1:0]         ch,
		input logic signed [COEF_W-1:0] k
	);
		logic signed [PROD_W-1:0] p;
		p = $signed({1'b0, ch}) * k;
		return p;
	endfunction

	// floor by 2^FRAC_BITS, then saturate to the pixel range
	function automatic logic [PIX_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
		logic [PIX_W-1:0] r;
		if (s[SUM_W-1]) begin
			r = '0;
		end else if (|s[SUM_W-2:FRAC_BITS+PIX_W]) begin
			r = '1;
		end else begin
			r = s[FRAC_BITS+PIX_W-1:FRAC_BITS];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/rgbc_line_store.sv */
// Line store memory: upper and lower row pixels of one column in one word.
// One write port, one read port with registered read data; uses rgbc_pkg.
module rgbc_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [rgbc_pkg::LINE_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [rgbc_pkg::LINE_W-1:0] wr_data
);

	logic [rgbc_pkg::LINE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/rgbc_tap_cell.sv */
// One window column of the 3x3 filter: three pixels, nine products, column sums.
// Hands its column to the next older cell on every shift; uses rgbc_pkg.
module rgbc_tap_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rgbc_pkg::cell_ctl_t  ctl,
	input  logic                 col_ok,
	input  rgbc_pkg::coef_col_t  coef,
	input  rgbc_pkg::win_col_t   col_in,
	output rgbc_pkg::win_col_t   col_out,
	output rgbc_pkg::col_sum_t   sum
);

	rgbc_pkg::win_col_t col_q;
	rgbc_pkg::pix_t     row_px [3];
	logic signed [rgbc_pkg::COEF_W-1:0] row_k [3];
	logic        [2:0]  row_ok;
	logic signed [rgbc_pkg::PROD_W-1:0] prod_s3 [3][3];
	logic signed [rgbc_pkg::COL_SUM_W-1:0] acc [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	always_comb begin
		row_px[0] = col_q.top;
		row_px[1] = col_q.mid;
		row_px[2] = col_q.bot;
		row_ok    = {ctl.bot_ok, 1'b1, ctl.top_ok};
		// out-of-frame taps: drop the coefficient
		row_k[0]  = (row_ok[0] && col_ok) ? coef.top : '0;
		row_k[1]  = col_ok ? coef.mid : '0;
		row_k[2]  = (row_ok[2] && col_ok) ? coef.bot : '0;
	end

	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			for (int r = 0; r < 3; r++) begin
				prod_s3[r][0] <= rgbc_pkg::mul_tap(row_px[r].red, row_k[r]);
				prod_s3[r][1] <= rgbc_pkg::mul_tap(row_px[r].green, row_k[r]);
				prod_s3[r][2] <= rgbc_pkg::mul_tap(row_px[r].blue, row_k[r]);
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			acc[ch] = rgbc_pkg::COL_SUM_W'(prod_s3[0][ch])
				+ rgbc_pkg::COL_SUM_W'(prod_s3[1][ch])
				+ rgbc_pkg::COL_SUM_W'(prod_s3[2][ch]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			sum.red   <= acc[0];
			sum.green <= acc[1];
			sum.blue  <= acc[2];
		end
	end

endmodule

/* hw/rtl/rgb_conv3x3_filter.sv */
// Top level of the streaming RGB 3x3 convolution filter.
// Depends on rgbc_pkg, rgbc_line_store and rgbc_tap_cell.
//
// Takes one pixel word per clock and gives one filtered word per clock once the
// 3x3 window is full, while the output is not stalled: the result for pixel (x,y) is
// completed by input item y*W+x+W+1 and reaches the master side via stages s1 to s4.
// The throughput of one word per clock is set by the line store, which does one
// read and one write per item, and by the row of three column cells that shift
// once per item. Send W+1 flush words (tuser set) after a frame to drain it; a
// flush word inside a frame counts as a black pixel. The line store needs no
// clearing after reset. Coefficients are signed Q8.8, left tap in bits 15:0,
// center in 31:16, right in 47:32; sums are floored by 256 and clamped to 0..255.
module rgb_conv3x3_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rgbc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rgbc_pkg::CFG_ROW_W-1:0]     cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [23:0]                        s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                               s_axis_tuser,  // flush
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [23:0]                        m_axis_tdata,  // out_red, out_green, out_blue
	output logic                               m_axis_tlast
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = ($clog2(MAX_WIDTH + 1) > rgbc_pkg::CFG_DIM_W) ?
		$clog2(MAX_WIDTH + 1) : rgbc_pkg::CFG_DIM_W;
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int SH = ($clog2(MAX_HEIGHT + 1) > rgbc_pkg::CFG_DIM_W) ?
		$clog2(MAX_HEIGHT + 1) : rgbc_pkg::CFG_DIM_W;

	// configuration
	logic [rgbc_pkg::CFG_DIM_W-1:0] frame_width_q;
	logic [rgbc_pkg::CFG_DIM_W-1:0] frame_height_q;
	logic [rgbc_pkg::CFG_ROW_W-1:0] coef_top_q;
	logic [rgbc_pkg::CFG_ROW_W-1:0] coef_mid_q;
	logic [rgbc_pkg::CFG_ROW_W-1:0] coef_bot_q;
	logic [SW-1:0] eff_w;
	logic [SH-1:0] eff_h;

	// position state
	logic [CW-1:0]        in_col_q;
	rgbc_pkg::row_phase_t in_phase_q;
	rgbc_pkg::row_phase_t in_phase_n;
	logic [CW-1:0]        out_col_q;
	logic [RW-1:0]        out_row_q;
	logic                 in_col_end;
	logic                 out_col_end;
	logic                 out_row_end;
	rgbc_pkg::pos_flags_t flags;

	// pipeline
	logic                 en;
	logic                 accept;
	rgbc_pkg::pix_t       pix_in;
	logic                 v_s1;
	rgbc_pkg::pos_flags_t flags_s1;
	logic [CW-1:0]        idx_s1;
	rgbc_pkg::pix_t       pix_s1;
	logic                 fwd_s1;
	rgbc_pkg::pix_t       fwd_top_s1;
	rgbc_pkg::pix_t       fwd_mid_s1;
	logic [rgbc_pkg::LINE_W-1:0] rd_data;
	rgbc_pkg::pix_t       top_eff;
	rgbc_pkg::pix_t       mid_eff;
	logic                 v_s2;
	rgbc_pkg::pos_flags_t flags_s2;
	logic                 v_s3;
	logic                 last_s3;
	logic                 v_s4;
	logic                 last_s4;

	// window cells
	rgbc_pkg::cell_ctl_t  cell_ctl;
	rgbc_pkg::win_col_t   new_col;
	rgbc_pkg::win_col_t   col_in  [3];
	rgbc_pkg::win_col_t   col_out [3];
	rgbc_pkg::coef_col_t  cell_coef [3];
	logic [2:0]           cell_col_ok;
	rgbc_pkg::col_sum_t   cell_sum [3];

	// result and output buffering
	logic signed [rgbc_pkg::SUM_W-1:0] tot [3];
	rgbc_pkg::pix_t res_px;
	rgbc_pkg::pix_t out_px_q;
	logic           out_last_q;
	logic           out_valid_q;
	rgbc_pkg::pix_t skid_px_q;
	logic           skid_last_q;
	logic           skid_valid_q;
	logic           take;
	logic           load;
	logic           load_out;
	logic           load_skid;
	logic           from_skid;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rgbc_pkg::FRAME_WIDTH_RST;
			frame_height_q <= rgbc_pkg::FRAME_HEIGHT_RST;
			coef_top_q     <= rgbc_pkg::COEF_TOP_RST;
			coef_mid_q     <= rgbc_pkg::COEF_MID_RST;
			coef_bot_q     <= rgbc_pkg::COEF_BOT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rgbc_pkg::CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[rgbc_pkg::CFG_DIM_W-1:0];
				end
				rgbc_pkg::CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[rgbc_pkg::CFG_DIM_W-1:0];
				end
				rgbc_pkg::CFG_COEF_TOP: begin
					coef_top_q <= cfg_data;
				end
				rgbc_pkg::CFG_COEF_MID: begin
					coef_mid_q <= cfg_data;
				end
				rgbc_pkg::CFG_COEF_BOT: begin
					coef_bot_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// zero means one; clip the width to what the line store holds, the height to MAX_HEIGHT
	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = SW'(1);
		end else if (SW'(frame_width_q) > SW'(MAX_WIDTH)) begin
			eff_w = SW'(MAX_WIDTH);
		end else begin
			eff_w = SW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			eff_h = SH'(1);
		end else if (SH'(frame_height_q) > SH'(MAX_HEIGHT)) begin
			eff_h = SH'(MAX_HEIGHT);
		end else begin
			eff_h = SH'(frame_height_q);
		end
	end

	// ---------------- position tracking ----------------
	assign en            = !skid_valid_q;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && en;
	assign pix_in        = s_axis_tuser ? '0 : rgbc_pkg::pix_t'(s_axis_tdata);

	assign in_col_end  = (SW'(in_col_q) + SW'(1)) >= eff_w;
	assign out_col_end = (SW'(out_col_q) + SW'(1)) >= eff_w;
	assign out_row_end = (SH'(out_row_q) + SH'(1)) >= eff_h;

	always_comb begin
		flags.emit     = (in_phase_q == rgbc_pkg::ROW_LATER)
			|| (in_phase_q == rgbc_pkg::ROW_SECOND && in_col_q != '0);
		flags.left_ok  = out_col_q != '0;
		flags.right_ok = !out_col_end;
		flags.top_ok   = out_row_q != '0;
		flags.bot_ok   = !out_row_end;
		flags.last     = flags.emit && out_col_end && out_row_end;
	end

	always_comb begin
		in_phase_n = in_phase_q;
		if (in_col_end) begin
			case (in_phase_q)
				rgbc_pkg::ROW_FIRST:  in_phase_n = rgbc_pkg::ROW_SECOND;
				rgbc_pkg::ROW_SECOND: in_phase_n = rgbc_pkg::ROW_LATER;
				rgbc_pkg::ROW_LATER:  in_phase_n = rgbc_pkg::ROW_LATER;
				default:              in_phase_n = rgbc_pkg::ROW_FIRST;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_phase_q <= rgbc_pkg::ROW_FIRST;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (accept) begin
			if (flags.last) begin
				in_col_q   <= '0;
				in_phase_q <= rgbc_pkg::ROW_FIRST;
				out_col_q  <= '0;
				out_row_q  <= '0;
			end else begin
				in_col_q   <= in_col_end ? '0 : in_col_q + CW'(1);
				in_phase_q <= in_phase_n;
				if (flags.emit) begin
					if (out_col_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// ---------------- line store ----------------
	rgbc_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_col_q),
		.rd_data (rd_data),
		.wr_en   (en && v_s1),
		.wr_addr (idx_s1),
		.wr_data ({mid_eff, pix_s1})
	);

	// the word in s1 writes its column as the next word reads it: forward
	assign top_eff = fwd_s1 ? fwd_top_s1 : rgbc_pkg::pix_t'(rd_data[rgbc_pkg::LINE_W-1:24]);
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : rgbc_pkg::pix_t'(rd_data[23:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1 && flags_s1.emit;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1   <= flags;
			idx_s1     <= in_col_q;
			pix_s1     <= pix_in;
			fwd_s1     <= v_s1 && (idx_s1 == in_col_q);
			fwd_top_s1 <= mid_eff;
			fwd_mid_s1 <= pix_s1;
		end
		if (en) begin
			flags_s2 <= flags_s1;
			last_s3  <= flags_s2.last;
			last_s4  <= last_s3;
		end
	end

	// ---------------- window cells ----------------
	always_comb begin
		cell_ctl.shift = en && v_s1;
		cell_ctl.calc  = en;
		cell_ctl.top_ok = flags_s2.top_ok;
		cell_ctl.bot_ok = flags_s2.bot_ok;
		new_col.top = top_eff;
		new_col.mid = mid_eff;
		new_col.bot = pix_s1;
		cell_col_ok = {flags_s2.right_ok, 1'b1, flags_s2.left_ok};
	end

	for (genvar i = 0; i < 3; i++) begin : g_cell
		assign cell_coef[i].top = coef_top_q[i*rgbc_pkg::COEF_W +: rgbc_pkg::COEF_W];
		assign cell_coef[i].mid = coef_mid_q[i*rgbc_pkg::COEF_W +: rgbc_pkg::COEF_W];
		assign cell_coef[i].bot = coef_bot_q[i*rgbc_pkg::COEF_W +: rgbc_pkg::COEF_W];

		if (i == 2) begin : g_newest
			assign col_in[i] = new_col;
		end else begin : g_older
			assign col_in[i] = col_out[i+1];
		end

		rgbc_tap_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.col_ok  (cell_col_ok[i]),
			.coef    (cell_coef[i]),
			.col_in  (col_in[i]),
			.col_out (col_out[i]),
			.sum     (cell_sum[i])
		);
	end

	// ---------------- final sum, clamp, output ----------------
	always_comb begin
		tot[0] = rgbc_pkg::SUM_W'(cell_sum[0].red) + rgbc_pkg::SUM_W'(cell_sum[1].red)
			+ rgbc_pkg::SUM_W'(cell_sum[2].red);
		tot[1] = rgbc_pkg::SUM_W'(cell_sum[0].green) + rgbc_pkg::SUM_W'(cell_sum[1].green)
			+ rgbc_pkg::SUM_W'(cell_sum[2].green);
		tot[2] = rgbc_pkg::SUM_W'(cell_sum[0].blue) + rgbc_pkg::SUM_W'(cell_sum[1].blue)
			+ rgbc_pkg::SUM_W'(cell_sum[2].blue);
		res_px.red   = rgbc_pkg::clamp_chan(tot[0]);
		res_px.green = rgbc_pkg::clamp_chan(tot[1]);
		res_px.blue  = rgbc_pkg::clamp_chan(tot[2]);
	end

	always_comb begin
		take      = out_valid_q && m_axis_tready;
		load      = en && v_s4;
		from_skid = skid_valid_q && take;
		load_out  = load && (!out_valid_q || take);
		load_skid = load && out_valid_q && !take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (from_skid) begin
				skid_valid_q <= 1'b0;
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
			if (from_skid || load_out) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (from_skid) begin
			out_px_q   <= skid_px_q;
			out_last_q <= skid_last_q;
		end else if (load_out) begin
			out_px_q   <= res_px;
			out_last_q <= last_s4;
		end
		if (load_skid) begin
			skid_px_q   <= res_px;
			skid_last_q <= last_s4;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_px_q;
	assign m_axis_tlast  = out_last_q;

	// ---------------- assertions ----------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a word while the output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !m_axis_tready |=> skid_valid_q && $stable(skid_px_q))
		else $error("skid word lost or changed while output is stalled");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SW'(in_col_q) < SW'(MAX_WIDTH)) && (SW'(out_col_q) < SW'(MAX_WIDTH)))
		else $error("column counter beyond line store depth");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && flags.last |=> in_col_q == '0 && out_col_q == '0 && out_row_q == '0
			&& in_phase_q == rgbc_pkg::ROW_FIRST)
		else $error("position counters not cleared after the last pixel of a frame");

	a_window_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.shift |=> col_out[0] == $past(col_out[1]) && col_out[1] == $past(col_out[2]))
		else $error("window column not handed to its neighbor");

endmodule

/* bench/rgb_conv3x3_filter_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for rgb_conv3x3_filter: streams RGB frames with random gaps and stalls
// and compares every filtered word with a 3x3 convolution model kept inside the bench.
// Depends on rgbc_pkg and the filter RTL only.
module rgb_conv3x3_filter_tb;
	import rgbc_pkg::*;

	localparam int LINE_DEPTH    = 1024;
	localparam int ROW_LIMIT     = 1024;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_WORDS  = 500;
	localparam int REPORT_CAP    = 100;

	typedef struct {
		pix_t px;
		logic last;
	} filt_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index = CFG_FRAME_WIDTH;
	logic [CFG_ROW_W-1:0] cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;  // in_red, in_green, in_blue
	logic                 s_axis_tuser = 1'b0; // flush
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;       // out_red, out_green, out_blue
	logic                 m_axis_tlast;

	// register shadow and convolution state
	logic [CFG_DIM_W-1:0] width_reg = FRAME_WIDTH_RST;
	logic [CFG_DIM_W-1:0] height_reg = FRAME_HEIGHT_RST;
	logic [CFG_ROW_W-1:0] coef_rows[3] = '{COEF_TOP_RST, COEF_MID_RST, COEF_BOT_RST};
	cfg_reg_t             coef_regs[3] = '{CFG_COEF_TOP, CFG_COEF_MID, CFG_COEF_BOT};
	pix_t                 line_upper[LINE_DEPTH] = '{default: '0};
	pix_t                 line_lower[LINE_DEPTH] = '{default: '0};
	pix_t                 win[9] = '{default: '0};
	int unsigned          in_col = 0;
	int unsigned          in_row = 0;
	int unsigned          out_col = 0;
	int unsigned          out_row = 0;

	filt_word_t           expected_filtered[$];
	string                chan_name[3] = '{"red", "green", "blue"};
	int                   errors = 0;
	int unsigned          cycles = 0;
	int unsigned          words_sent = 0;
	bit                   tx_steady = 1'b0;
	bit                   rx_steady = 1'b0;

	rgb_conv3x3_filter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[rgb_conv3x3_filter] ERROR");
			$finish;
		end
	end

	function automatic int unsigned eff_dim(input logic [CFG_DIM_W-1:0] v, input int unsigned cap);
		if (v == '0) return 1;
		if (v > cap) return cap;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] clamp_level(input int s);
		if (s < 0) return '0;
		if (s >= (1 << (FRAC_BITS + PIX_W))) return '1;
		return PIX_W'(s >>> FRAC_BITS);
	endfunction

	// advance the window by one word and queue the filtered pixel it completes, if any
	task automatic convolve_word(input pix_t px, input logic flush);
		int unsigned w, h, slot;
		int          r, c, k, acc_r, acc_g, acc_b;
		pix_t        p, top, mid, tap;
		logic        emit;
		filt_word_t  res;
		w = eff_dim(width_reg, LINE_DEPTH);
		h = eff_dim(height_reg, ROW_LIMIT);
		p = flush ? pix_t'('0) : px;
		slot = in_col % LINE_DEPTH;
		top = line_upper[slot];
		mid = line_lower[slot];
		line_upper[slot] = mid;
		line_lower[slot] = p;
		for (r = 0; r < 3; r++) begin
			win[r*3]   = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = p;

		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row++;
		end else begin
			in_col++;
		end
		if (!emit) return;

		acc_r = 0;
		acc_g = 0;
		acc_b = 0;
		for (r = 0; r < 3; r++) begin
			// drop taps that fall outside the frame
			if ((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h)) continue;
			for (c = 0; c < 3; c++) begin
				if ((c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w)) continue;
				k = int'($signed(coef_rows[r][COEF_W*c +: COEF_W]));
				tap = win[r*3+c];
				acc_r += int'(tap.red) * k;
				acc_g += int'(tap.green) * k;
				acc_b += int'(tap.blue) * k;
			end
		end
		res.px.red   = clamp_level(acc_r);
		res.px.green = clamp_level(acc_g);
		res.px.blue  = clamp_level(acc_b);
		res.last     = (out_col + 1 >= w) && (out_row + 1 >= h);
		expected_filtered.push_back(res);

		if (res.last) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
	endtask

	task automatic send_word(input pix_t px, input logic flush);
		int gap;
		if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
		gap = tx_steady ? 0 : $urandom_range(0, 12);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = px;
		s_axis_tuser  = flush;
		do @(posedge clk); while (!s_axis_tready);
		convolve_word(px, flush);
		words_sent++;
	endtask

	// one full frame plus its drain; pixels inside the frame are flushed one in flush_odds
	task automatic send_frame(input int flush_odds);
		int unsigned w, h, n;
		w = eff_dim(width_reg, LINE_DEPTH);
		h = eff_dim(height_reg, ROW_LIMIT);
		for (n = 0; n < w * h; n++)
			send_word(pix_t'(24'($urandom())), flush_odds > 0 && $urandom_range(1, flush_odds) == 1);
		for (n = 0; n <= w; n++)
			send_word(pix_t'(24'($urandom())), $urandom_range(0, 7) != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_ROW_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FRAME_WIDTH:  width_reg = value[CFG_DIM_W-1:0];
			CFG_FRAME_HEIGHT: height_reg = value[CFG_DIM_W-1:0];
			CFG_COEF_TOP:     coef_rows[0] = value;
			CFG_COEF_MID:     coef_rows[1] = value;
			CFG_COEF_BOT:     coef_rows[2] = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// hold the input, then wait for all words plus the pipeline depth
	task automatic let_block_idle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_filtered.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_random_kernel();
		logic [CFG_ROW_W-1:0] row;
		int                   r, c, style;
		style = $urandom_range(0, 2);
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 3; c++) begin
				case (style)
					0:       row[COEF_W*c +: COEF_W] = COEF_W'($urandom_range(0, 640) - 320);
					1:       row[COEF_W*c +: COEF_W] = COEF_W'($urandom());
					default: row[COEF_W*c +: COEF_W] = COEF_W'($urandom_range(0, 64));
				endcase
			end
			write_reg(coef_regs[r], row);
		end
	endtask

	// reset coefficients pass the center tap through; extremes, in-frame flush, pixel in drain
	task automatic test_pass_through();
		write_reg(CFG_FRAME_WIDTH, 3);
		write_reg(CFG_FRAME_HEIGHT, 2);
		send_word(24'h000000, 1'b0);
		send_word(24'hFFFFFF, 1'b0);
		send_word(24'h0000FF, 1'b0);
		send_word(24'h00FF00, 1'b0);
		send_word(24'hFF0000, 1'b0);
		send_word(24'h5A5A5A, 1'b1);
		send_word(24'h123456, 1'b1);
		send_word(24'hABCDEF, 1'b0);
		send_word(24'h000000, 1'b1);
		send_word(24'h000000, 1'b1);
	endtask

	// zero size reads as 1x1; largest and most negative taps saturate both ways
	task automatic test_unit_frame();
		int r;
		let_block_idle();
		write_reg(CFG_FRAME_WIDTH, 0);
		write_reg(CFG_FRAME_HEIGHT, 0);
		for (r = 0; r < 3; r++) write_reg(coef_regs[r], 48'h7FFF_7FFF_7FFF);
		send_word(24'h0180FF, 1'b0);
		send_word(24'h000000, 1'b1);
		send_word(24'h000000, 1'b1);
		let_block_idle();
		for (r = 0; r < 3; r++) write_reg(coef_regs[r], 48'h8000_8000_8000);
		send_word(24'hFFFFFF, 1'b0);
		send_word(24'h000000, 1'b1);
		send_word(24'h000000, 1'b1);
	endtask

	// shrink both dimensions once two rows are stored; the frame must close early
	task automatic test_resize_mid_frame();
		int n;
		let_block_idle();
		write_reg(CFG_FRAME_WIDTH, 4);
		write_reg(CFG_FRAME_HEIGHT, 4);
		load_random_kernel();
		repeat (10) send_word(pix_t'(24'($urandom())), 1'b0);
		let_block_idle();
		write_reg(CFG_FRAME_WIDTH, 2);
		write_reg(CFG_FRAME_HEIGHT, 2);
		n = 0;
		while ((in_col != 0 || in_row != 0 || out_col != 0 || out_row != 0) && n < 4096) begin
			send_word(pix_t'(24'($urandom())), 1'b0);
			n++;
		end
	endtask

	task automatic test_random_frames();
		int unsigned start;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			let_block_idle();
			if ($urandom_range(0, 9) == 0)
				write_reg(CFG_FRAME_WIDTH, $urandom_range(13, 48));
			else
				write_reg(CFG_FRAME_WIDTH, $urandom_range(0, 12));
			write_reg(CFG_FRAME_HEIGHT, $urandom_range(0, 8));
			if ($urandom_range(0, 3) != 0) load_random_kernel();
			repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 8));
		end
	endtask

	// sizes above the line length and row limit saturate
	task automatic test_size_limits();
		let_block_idle();
		write_reg(CFG_FRAME_WIDTH, 11'h7FF);
		write_reg(CFG_FRAME_HEIGHT, 1);
		load_random_kernel();
		send_frame(16);
		let_block_idle();
		write_reg(CFG_FRAME_WIDTH, 1);
		write_reg(CFG_FRAME_HEIGHT, 11'h7FF);
		send_frame(16);
	endtask

	initial begin : result_check
		filt_word_t  want;
		logic [23:0] got;
		int          stall, ch;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 12);
			repeat (stall) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
			end
			@(negedge clk);
			m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got = m_axis_tdata;
			if (expected_filtered.size() == 0) begin
				if (errors < REPORT_CAP)
					$display("%0t: word with none expected, got %06h last %0b",
						$time, got, m_axis_tlast);
				errors++;
				continue;
			end
			want = expected_filtered.pop_front();
			for (ch = 0; ch < 3; ch++) begin
				if (got[PIX_W*ch +: PIX_W] !== want.px[PIX_W*ch +: PIX_W]) begin
					if (errors < REPORT_CAP)
						$display("%0t: %s expected %0d, got %0d", $time, chan_name[ch],
							want.px[PIX_W*ch +: PIX_W], got[PIX_W*ch +: PIX_W]);
					errors++;
				end
			end
			if (m_axis_tlast !== want.last) begin
				if (errors < REPORT_CAP)
					$display("%0t: frame_last expected %0b, got %0b", $time, want.last,
						m_axis_tlast);
				errors++;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_pass_through();
		test_unit_frame();
		test_resize_mid_frame();
		test_random_frames();
		test_size_limits();
		let_block_idle();
		if (errors == 0) begin
			$display("[rgb_conv3x3_filter] OK");
		end else begin
			$display("[rgb_conv3x3_filter] ERROR");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/rgbc_pkg.sv
hw/rtl/rgbc_line_store.sv
hw/rtl/rgbc_tap_cell.sv
hw/rtl/rgb_conv3x3_filter.sv
bench/rgb_conv3x3_filter_tb.sv
